@@ rtl/frr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frr_pkg
// Shared constants and register codes of the Fresnel reflect/refract pipeline.
// ----------------------------------------------------------------------------
package frr_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int CFG_ADDR_W    = 4;
	localparam int CFG_DATA_W    = 32;

	localparam logic [15:0] INDEX_INSIDE_RST  = 16'd14746;
	localparam logic [15:0] INDEX_OUTSIDE_RST = 16'd16384;
	localparam logic [7:0]  MAX_BOUNCES_RST   = 8'd4;

	typedef enum logic [1:0] {
		REG_INDEX_INSIDE  = 2'd0,
		REG_INDEX_OUTSIDE = 2'd1,
		REG_MAX_BOUNCES   = 2'd2
	} cfg_reg_t;

endpackage
`default_nettype wire

@@ rtl/frr_div_pipe.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frr_div_pipe
// Pipelined restoring divider, several lanes side by side, one quotient bit
// per stage. The numerator's upper DW bits must be below the divisor.
// ----------------------------------------------------------------------------
module frr_div_pipe #(
	parameter int LANES = 1,
	parameter int DW    = 8,
	parameter int QW    = 8,
	parameter int SW    = 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [LANES-1:0][QW+DW-1:0]      num,
	input  logic [LANES-1:0][DW-1:0]         den,
	input  logic [SW-1:0]                    side_in,
	output logic                             out_valid,
	output logic [LANES-1:0][QW-1:0]         quo,
	output logic [SW-1:0]                    side_out
);

	logic                            vld_s  [QW+1];
	logic [LANES-1:0][DW-1:0]        rem_s  [QW+1];
	logic [LANES-1:0][DW-1:0]        den_s  [QW+1];
	logic [LANES-1:0][QW-1:0]        quo_s  [QW+1];
	logic [SW-1:0]                   side_s [QW+1];

	assign vld_s[0]  = in_valid;
	assign side_s[0] = side_in;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			rem_s[0][l] = num[l][QW+DW-1:QW];
			quo_s[0][l] = num[l][QW-1:0];
			den_s[0][l] = den[l];
		end
	end

	for (genvar g = 0; g < QW; g++) begin : g_stage
		logic [LANES-1:0][DW:0] trial;
		logic [LANES-1:0]       ge;

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				trial[l] = {rem_s[g][l], quo_s[g][l][QW-1]};
				ge[l]    = trial[l] >= {1'b0, den_s[g][l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			for (int l = 0; l < LANES; l++) begin
				rem_s[g+1][l] <= ge[l] ? DW'(trial[l] - {1'b0, den_s[g][l]}) : trial[l][DW-1:0];
				quo_s[g+1][l] <= {quo_s[g][l][QW-2:0], ge[l]};
				den_s[g+1][l] <= den_s[g][l];
			end
			side_s[g+1] <= side_s[g];
		end
	end

	assign out_valid = vld_s[QW];
	assign quo       = quo_s[QW];
	assign side_out  = side_s[QW];

endmodule
`default_nettype wire

@@ rtl/frr_sqrt_pipe.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frr_sqrt_pipe
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module frr_sqrt_pipe #(
	parameter int RW = 8,
	parameter int SW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [2*RW-1:0]   rad,
	input  logic [SW-1:0]     side_in,
	output logic              out_valid,
	output logic [RW-1:0]     root,
	output logic [SW-1:0]     side_out
);

	logic              vld_s  [RW+1];
	logic [RW+1:0]     rem_s  [RW+1];
	logic [RW-1:0]     root_s [RW+1];
	logic [2*RW-1:0]   rad_s  [RW+1];
	logic [SW-1:0]     side_s [RW+1];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = rad;
	assign side_s[0] = side_in;

	for (genvar g = 0; g < RW; g++) begin : g_stage
		logic [RW+3:0] cur;
		logic [RW+3:0] trial;
		logic          ge;

		// bring down the next two radicand bits, try root*4+1
		assign cur   = {rem_s[g], rad_s[g][2*RW-1:2*RW-2]};
		assign trial = {2'b00, root_s[g], 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1]  <= ge ? (RW+2)'(cur - trial) : cur[RW+1:0];
			root_s[g+1] <= {root_s[g][RW-2:0], ge};
			rad_s[g+1]  <= {rad_s[g][2*RW-3:0], 2'b00};
			side_s[g+1] <= side_s[g];
		end
	end

	assign out_valid = vld_s[RW];
	assign root      = root_s[RW];
	assign side_out  = side_s[RW];

endmodule
`default_nettype wire

@@ rtl/fresnel_refract_reflect.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fresnel_refract_reflect
// Fresnel reflect-or-refract decision for one ray at a dielectric surface.
// ----------------------------------------------------------------------------
// Usage:
//  Raise start with the incident direction, normal, random value and bounce
//  count; the item is taken at that edge. busy never rises: an item may enter
//  in every cycle and the sustained rate is one item per clock.
//  Each result shows on out_* for one cycle with done high, in input order.
//  The pipeline is a chain of one-bit-per-stage units: the Snell /
//  ratio divider (FRAC_BITS+17 stages), the square root (FRAC_BITS+1) and the
//  Fresnel divider (FRAC_BITS), plus ten stages of products and sums.
//  The receiver cannot stall; results are never held.
//  Registers sit on an APB port: index_inside at 0x0, index_outside at 0x4,
//  max_bounces at 0x8; write them only while no item is in flight.
//  Reset clears the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
module fresnel_refract_reflect #(
	parameter int FRAC_BITS = frr_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [15:0]              incident_x,
	input  logic signed [15:0]              incident_y,
	input  logic signed [15:0]              incident_z,
	input  logic signed [15:0]              normal_x,
	input  logic signed [15:0]              normal_y,
	input  logic signed [15:0]              normal_z,
	input  logic [15:0]                     random_value,
	input  logic [7:0]                      bounce_count,
	output logic                            done,
	output logic signed [15:0]              out_x,
	output logic signed [15:0]              out_y,
	output logic signed [15:0]              out_z,
	output logic [7:0]                      out_bounces,
	output logic                            was_reflected,
	output logic                            total_internal,
	output logic                            terminated,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [frr_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [frr_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [frr_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready
);

	import frr_pkg::*;

	localparam int F   = FRAC_BITS;
	localparam int QW1 = F + 17;
	localparam int DW1 = 32;
	localparam int QW2 = F;
	localparam int DW2 = F + 18;
	localparam int VW  = F + 36;
	localparam logic [F:0] UNIT = {1'b1, {F{1'b0}}};

	typedef struct packed {
		logic [2:0][15:0] inc;
		logic [2:0][16:0] nrm;
		logic [15:0]      rv;
		logic [7:0]       bc;
		logic             term;
		logic [15:0]      n1;
		logic [15:0]      n2;
		logic [F:0]       ci;
	} base_t;

	typedef struct packed {
		base_t b;
		logic  tir;
	} d1_t;

	typedef struct packed {
		d1_t          d;
		logic [F+15:0] ratio;
		logic [F+16:0] kq;
	} sq_t;

	typedef struct packed {
		sq_t        s;
		logic [F:0] ct;
		logic       satt;
		logic       satl;
	} fr_t;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [15:0] index_inside_q;
	logic [15:0] index_outside_q;
	logic [7:0]  max_bounces_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_inside_q  <= INDEX_INSIDE_RST;
			index_outside_q <= INDEX_OUTSIDE_RST;
			max_bounces_q   <= MAX_BOUNCES_RST;
		end else if (cfg_wr) begin
			unique case (cfg_reg_t'(paddr[3:2]))
				REG_INDEX_INSIDE:  index_inside_q  <= pwdata[15:0];
				REG_INDEX_OUTSIDE: index_outside_q <= pwdata[15:0];
				REG_MAX_BOUNCES:   max_bounces_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_reg_t'(paddr[3:2]))
			REG_INDEX_INSIDE:  prdata = CFG_DATA_W'(index_inside_q);
			REG_INDEX_OUTSIDE: prdata = CFG_DATA_W'(index_outside_q);
			REG_MAX_BOUNCES:   prdata = CFG_DATA_W'(max_bounces_q);
			default:           prdata = '0;
		endcase
	end

	assign busy = 1'b0;

	// ------------------------------------------------------------------
	// stage 1: component products, bounce check
	// ------------------------------------------------------------------
	logic signed [15:0] inc_in [3];
	logic signed [15:0] nrm_in [3];

	assign inc_in[0] = incident_x;
	assign inc_in[1] = incident_y;
	assign inc_in[2] = incident_z;
	assign nrm_in[0] = normal_x;
	assign nrm_in[1] = normal_y;
	assign nrm_in[2] = normal_z;

	logic               v_s1;
	logic [2:0][15:0]   inc_s1;
	logic [2:0][15:0]   nrm_s1;
	logic signed [31:0] prod_s1 [3];
	logic [15:0]        rv_s1;
	logic [7:0]         bc_s1;
	logic               term_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			inc_s1[i]  <= inc_in[i];
			nrm_s1[i]  <= nrm_in[i];
			prod_s1[i] <= inc_in[i] * nrm_in[i];
		end
		rv_s1   <= random_value;
		bc_s1   <= bounce_count;
		term_s1 <= bounce_count > max_bounces_q;
	end

	// ------------------------------------------------------------------
	// stage 2: dot product, side of the surface, |cos| clamp
	// ------------------------------------------------------------------
	logic signed [33:0] dot_c;
	logic               inside_c;
	logic [33:0]        mag_c;
	logic [33:0]        cis_c;
	logic [15:0]        n1_raw_c;
	logic [15:0]        n2_raw_c;
	base_t              base_c;

	always_comb begin
		dot_c    = 34'(prod_s1[0]) + 34'(prod_s1[1]) + 34'(prod_s1[2]);
		inside_c = dot_c > 34'sd0;
		mag_c    = dot_c[33] ? 34'(-dot_c) : 34'(dot_c);
		cis_c    = mag_c >> F;
		n1_raw_c = inside_c ? index_inside_q : index_outside_q;
		n2_raw_c = inside_c ? index_outside_q : index_inside_q;
		base_c.inc  = inc_s1;
		base_c.rv   = rv_s1;
		base_c.bc   = bc_s1;
		base_c.term = term_s1;
		base_c.n1   = (n1_raw_c == 16'd0) ? 16'd1 : n1_raw_c;
		base_c.n2   = (n2_raw_c == 16'd0) ? 16'd1 : n2_raw_c;
		base_c.ci   = (cis_c > 34'(UNIT)) ? UNIT : cis_c[F:0];
		for (int i = 0; i < 3; i++) begin
			// flip the normal when the ray leaves the material
			base_c.nrm[i] = inside_c ? 17'(-$signed(17'($signed(nrm_s1[i]))))
			                         : 17'($signed(nrm_s1[i]));
		end
	end

	logic  v_s2;
	base_t base_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		base_s2 <= base_c;
	end

	// ------------------------------------------------------------------
	// stage 3: squares, n1*cos
	// ------------------------------------------------------------------
	logic          v_s3;
	base_t         base_s3;
	logic [2*F+1:0] cici_s3;
	logic [31:0]   n1sq_s3;
	logic [31:0]   n2sq_s3;
	logic [F+16:0] a0_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		base_s3 <= base_s2;
		cici_s3 <= base_s2.ci * base_s2.ci;
		n1sq_s3 <= base_s2.n1 * base_s2.n1;
		n2sq_s3 <= base_s2.n2 * base_s2.n2;
		a0_s3   <= base_s2.n1 * base_s2.ci;
	end

	// ------------------------------------------------------------------
	// stage 4: n1^2 * (1 - cos^2)
	// ------------------------------------------------------------------
	logic [F:0]    s_c;
	logic          v_s4;
	base_t         base_s4;
	logic [F+32:0] nn_s4;
	logic [31:0]   n2sq_s4;
	logic [F+16:0] a0_s4;

	assign s_c = UNIT - (F+1)'(cici_s3 >> F);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		base_s4 <= base_s3;
		nn_s4   <= n1sq_s3 * s_c;
		n2sq_s4 <= n2sq_s3;
		a0_s4   <= a0_s3;
	end

	// ------------------------------------------------------------------
	// stage 5: total internal reflection test, sin^2 above one
	// ------------------------------------------------------------------
	logic [F+32:0] lim_c;
	logic          v_s5;
	base_t         base_s5;
	logic          tir_s5;
	logic [F+32:0] nn_s5;
	logic [31:0]   n2sq_s5;
	logic [F+16:0] a0_s5;

	assign lim_c = {1'b0, n2sq_s4, {F{1'b0}}} + (F+33)'(n2sq_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		base_s5 <= base_s4;
		tir_s5  <= nn_s4 >= lim_c;
		nn_s5   <= nn_s4;
		n2sq_s5 <= n2sq_s4;
		a0_s5   <= a0_s4;
	end

	// ------------------------------------------------------------------
	// divider 1: sin^2 of the transmitted angle, n1/n2, n1*cos/n2
	// ------------------------------------------------------------------
	logic [2:0][QW1+DW1-1:0] d1_num;
	logic [2:0][DW1-1:0]     d1_den;
	d1_t                     d1_in;
	d1_t                     d1_out;
	logic [2:0][QW1-1:0]     d1_quo;
	logic                    d1_vld;

	always_comb begin
		// drop the numerator on total reflection so the quotient stays in range
		d1_num[0] = tir_s5 ? '0 : (QW1+DW1)'(nn_s5);
		d1_num[1] = (QW1+DW1)'({base_s5.n1, {F{1'b0}}});
		d1_num[2] = (QW1+DW1)'(a0_s5);
		d1_den[0] = n2sq_s5;
		d1_den[1] = DW1'(base_s5.n2);
		d1_den[2] = DW1'(base_s5.n2);
		d1_in.b   = base_s5;
		d1_in.tir = tir_s5;
	end

	frr_div_pipe #(
		.LANES (3),
		.DW    (DW1),
		.QW    (QW1),
		.SW    ($bits(d1_t))
	) u_div_snell (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.num       (d1_num),
		.den       (d1_den),
		.side_in   (d1_in),
		.out_valid (d1_vld),
		.quo       (d1_quo),
		.side_out  (d1_out)
	);

	// ------------------------------------------------------------------
	// square root: cos of the transmitted angle
	// ------------------------------------------------------------------
	logic [F:0]     diff_c;
	logic [2*F+1:0] rad_c;
	sq_t            sq_in;
	sq_t            sq_out;
	logic [F:0]     root;
	logic           sq_vld;

	always_comb begin
		diff_c       = UNIT - d1_quo[0][F:0];
		rad_c        = {1'b0, diff_c, {F{1'b0}}};
		sq_in.d      = d1_out;
		sq_in.ratio  = d1_quo[1][F+15:0];
		sq_in.kq     = d1_quo[2];
	end

	frr_sqrt_pipe #(
		.RW (F + 1),
		.SW ($bits(sq_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d1_vld),
		.rad       (rad_c),
		.side_in   (sq_in),
		.out_valid (sq_vld),
		.root      (root),
		.side_out  (sq_out)
	);

	// ------------------------------------------------------------------
	// m1: Fresnel cross products
	// ------------------------------------------------------------------
	logic [F:0]    ct_c;
	logic          v_m1;
	sq_t           sq_m1;
	logic [F:0]    ct_m1;
	logic [F+16:0] a_m1;
	logic [F+16:0] b_m1;
	logic [F+16:0] c_m1;
	logic [F+16:0] d_m1;

	assign ct_c = sq_out.d.tir ? '0 : root;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
		end else begin
			v_m1 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		sq_m1 <= sq_out;
		ct_m1 <= ct_c;
		a_m1  <= sq_out.d.b.n1 * sq_out.d.b.ci;
		b_m1  <= sq_out.d.b.n2 * ct_c;
		c_m1  <= sq_out.d.b.n2 * sq_out.d.b.ci;
		d_m1  <= sq_out.d.b.n1 * ct_c;
	end

	// ------------------------------------------------------------------
	// m2: Fresnel numerators and denominators
	// ------------------------------------------------------------------
	logic [DW2-1:0] sumt_c;
	logic [DW2-1:0] sufl_c;
	logic [DW2-1:0] dift_c;
	logic [DW2-1:0] difl_c;
	logic           satt_c;
	logic           satl_c;

	always_comb begin
		sumt_c = DW2'(a_m1) + DW2'(b_m1);
		sufl_c = DW2'(c_m1) + DW2'(d_m1);
		dift_c = (a_m1 > b_m1) ? DW2'(a_m1 - b_m1) : DW2'(b_m1 - a_m1);
		difl_c = (c_m1 > d_m1) ? DW2'(c_m1 - d_m1) : DW2'(d_m1 - c_m1);
		// a zero denominator or a ratio of one saturates the term to 1.0
		satt_c = (sumt_c == '0) || (dift_c >= sumt_c);
		satl_c = (sufl_c == '0) || (difl_c >= sufl_c);
	end

	logic                     v_m2;
	fr_t                      fr_m2;
	logic [1:0][QW2+DW2-1:0]  num_m2;
	logic [1:0][DW2-1:0]      den_m2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m2 <= 1'b0;
		end else begin
			v_m2 <= v_m1;
		end
	end

	always_ff @(posedge clk) begin
		fr_m2.s    <= sq_m1;
		fr_m2.ct   <= ct_m1;
		fr_m2.satt <= satt_c;
		fr_m2.satl <= satl_c;
		num_m2[0]  <= satt_c ? '0 : {dift_c, {QW2{1'b0}}};
		num_m2[1]  <= satl_c ? '0 : {difl_c, {QW2{1'b0}}};
		den_m2[0]  <= sumt_c;
		den_m2[1]  <= sufl_c;
	end

	// ------------------------------------------------------------------
	// divider 2: Fresnel amplitude terms
	// ------------------------------------------------------------------
	fr_t                 fr_out;
	logic [1:0][QW2-1:0] d2_quo;
	logic                d2_vld;

	frr_div_pipe #(
		.LANES (2),
		.DW    (DW2),
		.QW    (QW2),
		.SW    ($bits(fr_t))
	) u_div_fresnel (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_m2),
		.num       (num_m2),
		.den       (den_m2),
		.side_in   (fr_m2),
		.out_valid (d2_vld),
		.quo       (d2_quo),
		.side_out  (fr_out)
	);

	// ------------------------------------------------------------------
	// r1: squares of the terms, direction products
	// ------------------------------------------------------------------
	logic [F:0]          rt_c;
	logic [F:0]          rl_c;
	logic signed [F+17:0] k_c;

	always_comb begin
		rt_c = fr_out.satt ? UNIT : {1'b0, d2_quo[0]};
		rl_c = fr_out.satl ? UNIT : {1'b0, d2_quo[1]};
		k_c  = $signed({1'b0, fr_out.s.kq}) - $signed({{17{1'b0}}, fr_out.ct});
	end

	logic                 v_r1;
	logic [2*F+1:0]       rt2_r1;
	logic [2*F+1:0]       rl2_r1;
	logic signed [F+18:0] cn_r1 [3];
	logic signed [F+32:0] rp_r1 [3];
	logic signed [F+34:0] kn_r1 [3];
	logic [2:0][15:0]     inc_r1;
	logic [15:0]          rv_r1;
	logic [7:0]           bc_r1;
	logic                 term_r1;
	logic                 tir_r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_r1 <= 1'b0;
		end else begin
			v_r1 <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		rt2_r1 <= rt_c * rt_c;
		rl2_r1 <= rl_c * rl_c;
		for (int i = 0; i < 3; i++) begin
			cn_r1[i] <= $signed({1'b0, fr_out.s.d.b.ci}) * $signed(fr_out.s.d.b.nrm[i]);
			rp_r1[i] <= $signed({1'b0, fr_out.s.ratio}) * $signed(fr_out.s.d.b.inc[i]);
			kn_r1[i] <= k_c * $signed(fr_out.s.d.b.nrm[i]);
		end
		inc_r1  <= fr_out.s.d.b.inc;
		rv_r1   <= fr_out.s.d.b.rv;
		bc_r1   <= fr_out.s.d.b.bc;
		term_r1 <= fr_out.s.d.b.term;
		tir_r1  <= fr_out.s.d.tir;
	end

	// ------------------------------------------------------------------
	// r2: reflectance, decision, candidate directions
	// ------------------------------------------------------------------
	logic [F:0] refl_c;

	assign refl_c = tir_r1 ? UNIT
	                       : (F+1)'(((2*F+3)'(rt2_r1) + (2*F+3)'(rl2_r1)) >> (F + 1));

	logic              v_r2;
	logic              reflect_r2;
	logic signed [VW-1:0] rfl_r2 [3];
	logic signed [VW-1:0] rfr_r2 [3];
	logic [7:0]        bc_r2;
	logic              term_r2;
	logic              tir_r2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_r2 <= 1'b0;
		end else begin
			v_r2 <= v_r1;
		end
	end

	always_ff @(posedge clk) begin
		reflect_r2 <= {rv_r1, {F{1'b0}}} < {refl_c, 16'h0000};
		for (int i = 0; i < 3; i++) begin
			rfl_r2[i] <= (VW'($signed(inc_r1[i])) <<< F) + (VW'(cn_r1[i]) <<< 1);
			rfr_r2[i] <= VW'(rp_r1[i]) + VW'(kn_r1[i]);
		end
		bc_r2   <= bc_r1;
		term_r2 <= term_r1;
		tir_r2  <= tir_r1;
	end

	// ------------------------------------------------------------------
	// r3: select, floor away F fraction bits, saturate, zero on termination, count the bounce
	// ------------------------------------------------------------------
	logic signed [VW-1:0] sel_c [3];
	logic signed [15:0]   dir_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sel_c[i] = (reflect_r2 ? rfl_r2[i] : rfr_r2[i]) >>> F;
			if (sel_c[i] > 32767) begin
				dir_c[i] = 16'sh7FFF;
			end else if (sel_c[i] < -32768) begin
				dir_c[i] = 16'sh8000;
			end else begin
				dir_c[i] = sel_c[i][15:0];
			end
		end
	end

	logic               done_q;
	logic signed [15:0] dir_q [3];
	logic [7:0]         bounces_q;
	logic               reflected_q;
	logic               tir_q;
	logic               term_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_r2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dir_q[i] <= term_r2 ? 16'sh0000 : dir_c[i];
		end
		bounces_q   <= (bc_r2 == 8'hFF) ? 8'hFF : bc_r2 + 8'd1;
		reflected_q <= ~term_r2 & reflect_r2;
		tir_q       <= ~term_r2 & tir_r2;
		term_q      <= term_r2;
	end

	assign done           = done_q;
	assign out_x          = dir_q[0];
	assign out_y          = dir_q[1];
	assign out_z          = dir_q[2];
	assign out_bounces    = bounces_q;
	assign was_reflected  = reflected_q;
	assign total_internal = tir_q;
	assign terminated     = term_q;

endmodule
`default_nettype wire

@@ tb/fresnel_refract_reflect_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fresnel_refract_reflect_test
// Drives rays through the Fresnel reflect/refract pipeline under several
// index and bounce-limit settings, predicts each direction and flag, and
// compares every result against the oldest prediction in order.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic signed [15:0] ix, iy, iz;
	logic signed [15:0] nx, ny, nz;
	logic [15:0]        rnd;
	logic [7:0]         bounces;
} ray_t;

typedef struct packed {
	logic signed [15:0] dx, dy, dz;
	logic [7:0]         bounces;
	logic               refl, tir, term;
} bounce_res_t;

class ray_scoreboard;
	bounce_res_t pending[$];
	int          errors;
	logic [15:0] n_in, n_out;
	logic [7:0]  limit;

	function new();
		errors = 0;
		n_in   = frr_pkg::INDEX_INSIDE_RST;
		n_out  = frr_pkg::INDEX_OUTSIDE_RST;
		limit  = frr_pkg::MAX_BOUNCES_RST;
	endfunction

	static function logic [15:0] clamp16(longint v);
		longint f;
		f = v >>> 14;
		if (f > 32767) f = 32767;
		if (f < -32768) f = -32768;
		return f[15:0];
	endfunction

	static function longint unsigned root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	static function longint unsigned qdiv(longint unsigned num, longint unsigned den);
		longint unsigned q, rem;
		q = 0;
		rem = num;
		if (den == 0 || rem >= den) return 64'd16384;
		for (int i = 0; i < 14; i++) begin
			rem <<= 1;
			q <<= 1;
			if (rem >= den) begin
				rem -= den;
				q |= 1;
			end
		end
		return q;
	endfunction

	function bounce_res_t fresnel_bounce(ray_t r);
		bounce_res_t e;
		longint inc[3], nrm[3], dot, mag, k, v;
		longint unsigned n1, n2, ci, s, st2, ct, a, b, c, d, rt, rl, fr, ratio;
		logic tir, refl;
		inc[0] = r.ix; inc[1] = r.iy; inc[2] = r.iz;
		nrm[0] = r.nx; nrm[1] = r.ny; nrm[2] = r.nz;
		e = '0;
		e.bounces = (r.bounces == 8'hFF) ? 8'hFF : r.bounces + 8'd1;
		if (r.bounces > limit) begin
			e.term = 1'b1;
			return e;
		end
		dot = inc[0] * nrm[0] + inc[1] * nrm[1] + inc[2] * nrm[2];
		if (dot > 0) begin
			n1 = n_in;
			n2 = n_out;
			for (int i = 0; i < 3; i++) nrm[i] = -nrm[i];
		end else begin
			n1 = n_out;
			n2 = n_in;
		end
		if (n1 == 0) n1 = 1;
		if (n2 == 0) n2 = 1;
		mag = (dot < 0) ? -dot : dot;
		ci = mag >> 14;
		if (ci > 16384) ci = 16384;
		s = 16384 - ((ci * ci) >> 14);
		st2 = (n1 * n1 * s) / (n2 * n2);
		tir = st2 > 16384;
		if (tir) begin
			ct = 0;
			fr = 16384;
		end else begin
			ct = root((16384 - st2) << 14);
			a = n1 * ci; b = n2 * ct;
			c = n2 * ci; d = n1 * ct;
			rt = qdiv(a > b ? a - b : b - a, a + b);
			rl = qdiv(c > d ? c - d : d - c, c + d);
			fr = (rt * rt + rl * rl) >> 15;
		end
		refl = ((64'(r.rnd) << 14) < (fr << 16));
		if (refl) begin
			v = inc[0] * 16384 + 2 * longint'(ci) * nrm[0]; e.dx = clamp16(v);
			v = inc[1] * 16384 + 2 * longint'(ci) * nrm[1]; e.dy = clamp16(v);
			v = inc[2] * 16384 + 2 * longint'(ci) * nrm[2]; e.dz = clamp16(v);
		end else begin
			ratio = (n1 << 14) / n2;
			k = longint'((n1 * ci) / n2) - longint'(ct);
			v = longint'(ratio) * inc[0] + k * nrm[0]; e.dx = clamp16(v);
			v = longint'(ratio) * inc[1] + k * nrm[1]; e.dy = clamp16(v);
			v = longint'(ratio) * inc[2] + k * nrm[2]; e.dz = clamp16(v);
		end
		e.refl = refl;
		e.tir = tir;
		return e;
	endfunction

	function void note_ray(ray_t r);
		pending.push_back(fresnel_bounce(r));
	endfunction

	task report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task check_result(bounce_res_t got);
		bounce_res_t e;
		if (pending.size() == 0) begin
			report("unexpected result", 1, 0);
			return;
		end
		e = pending.pop_front();
		if (got.dx !== e.dx) report("out_x", got.dx, e.dx);
		if (got.dy !== e.dy) report("out_y", got.dy, e.dy);
		if (got.dz !== e.dz) report("out_z", got.dz, e.dz);
		if (got.bounces !== e.bounces) report("out_bounces", got.bounces, e.bounces);
		if (got.refl !== e.refl) report("was_reflected", got.refl, e.refl);
		if (got.tir !== e.tir) report("total_internal", got.tir, e.tir);
		if (got.term !== e.term) report("terminated", got.term, e.term);
	endtask
endclass

module fresnel_refract_reflect_test;
	import frr_pkg::*;

	localparam int LATENCY = 3 * FRAC_BITS_DEF + 28;

	logic clk, arst_n, start, busy, done;
	logic signed [15:0] incident_x, incident_y, incident_z;
	logic signed [15:0] normal_x, normal_y, normal_z;
	logic [15:0] random_value;
	logic [7:0]  bounce_count;
	logic signed [15:0] out_x, out_y, out_z;
	logic [7:0]  out_bounces;
	logic was_reflected, total_internal, terminated;
	logic psel, penable, pwrite, pready;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata, prdata;

	ray_scoreboard sb;
	int burst_left;

	fresnel_refract_reflect dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk)
		if (arst_n && done)
			sb.check_result({out_x, out_y, out_z, out_bounces,
				was_reflected, total_internal, terminated});

	task write_reg(cfg_reg_t r, logic [31:0] val);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_W'(4 * r);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (r)
			REG_INDEX_INSIDE:  sb.n_in  = val[15:0];
			REG_INDEX_OUTSIDE: sb.n_out = val[15:0];
			default:           sb.limit = val[7:0];
		endcase
	endtask

	task drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task send_ray(ray_t r);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
		end
		burst_left--;
		start <= 1'b1;
		{incident_x, incident_y, incident_z, normal_x, normal_y, normal_z,
			random_value, bounce_count} <= r;
		do @(posedge clk); while (busy);
		sb.note_ray(r);
	endtask

	task idle_start();
		start <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] comp();
		case ($urandom_range(0, 5))
			0: return 16'sh4000;
			1: return 16'shC000;
			2: return 16'sh7FFF;
			3: return 16'sh8000;
			4: return 16'(int'($urandom_range(0, 32768)) - 16384);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic ray_t rand_ray();
		ray_t r;
		int p;
		p = $urandom_range(0, 9);
		r.nx = 0; r.ny = 0; r.nz = 0;
		case ($urandom_range(0, 2))
			0: r.nx = 16'sh4000;
			1: r.ny = 16'shC000;
			default: r.nz = 16'sh4000;
		endcase
		r.ix = 16'(int'($urandom_range(0, 32768)) - 16384);
		r.iy = 16'(int'($urandom_range(0, 32768)) - 16384);
		r.iz = 16'(int'($urandom_range(0, 32768)) - 16384);
		if (p < 3) begin
			r.ix = comp(); r.iy = comp(); r.iz = comp();
			r.nx = comp(); r.ny = comp(); r.nz = comp();
		end
		r.rnd = 16'($urandom);
		r.bounces = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
		return r;
	endfunction

	ray_t dir_rays[$];

	initial begin
		sb = new();
		burst_left = 0;
		arst_n = 1'b0;
		start = 1'b0;
		{incident_x, incident_y, incident_z, normal_x, normal_y, normal_z} = '0;
		random_value = '0;
		bounce_count = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// head-on, grazing, zero dot, inside, oversize, limits, terminate
		dir_rays.push_back({16'sh0000, 16'sh0000, 16'shC000, 16'sh0000, 16'sh0000,
			16'sh4000, 16'h0000, 8'd0});
		dir_rays.push_back({16'sh0000, 16'sh0000, 16'sh4000, 16'sh0000, 16'sh0000,
			16'sh4000, 16'hFFFF, 8'd1});
		dir_rays.push_back({16'sh4000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
			16'sh4000, 16'h8000, 8'd2});
		dir_rays.push_back({16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
			16'sh0000, 16'h1234, 8'd3});
		dir_rays.push_back({16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
			16'sh7FFF, 16'hFFFF, 8'd4});
		dir_rays.push_back({16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
			16'sh7FFF, 16'h0000, 8'd4});
		dir_rays.push_back({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
			16'sh8000, 16'h0001, 8'd0});
		dir_rays.push_back({16'sh3F00, 16'sh0000, 16'sh0800, 16'sh0000, 16'sh0000,
			16'sh4000, 16'h0000, 8'd0});
		dir_rays.push_back({16'sh2D41, 16'sh0000, 16'shD2BF, 16'sh0000, 16'sh0000,
			16'sh4000, 16'h4000, 8'd0});
		dir_rays.push_back({16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
			16'sh0000, 16'h0000, 8'd5});
		dir_rays.push_back({16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
			16'sh0000, 16'h0000, 8'd255});
		dir_rays.push_back({16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF,
			16'shFFFF, 16'hFFFF, 8'd254});
		foreach (dir_rays[i]) send_ray(dir_rays[i]);
		idle_start();
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					write_reg(REG_INDEX_INSIDE, 32'd24576);
					write_reg(REG_INDEX_OUTSIDE, 32'd16384);
					write_reg(REG_MAX_BOUNCES, 32'd255);
				end
				1: begin
					write_reg(REG_INDEX_INSIDE, 32'd0);
					write_reg(REG_INDEX_OUTSIDE, 32'd65535);
					write_reg(REG_MAX_BOUNCES, 32'd0);
				end
				2: begin
					write_reg(REG_INDEX_INSIDE, 32'd65535);
					write_reg(REG_INDEX_OUTSIDE, 32'd1);
					write_reg(REG_MAX_BOUNCES, 32'd8);
				end
				3: begin
					write_reg(REG_INDEX_INSIDE, 32'd16384);
					write_reg(REG_INDEX_OUTSIDE, 32'd16384);
				end
				4: begin
					write_reg(REG_INDEX_INSIDE, $urandom_range(8000, 40000));
					write_reg(REG_INDEX_OUTSIDE, $urandom_range(8000, 40000));
					write_reg(REG_MAX_BOUNCES, $urandom_range(0, 255));
				end
				default: begin
					write_reg(REG_INDEX_INSIDE, 32'(INDEX_INSIDE_RST));
					write_reg(REG_INDEX_OUTSIDE, 32'(INDEX_OUTSIDE_RST));
					write_reg(REG_MAX_BOUNCES, 32'(MAX_BOUNCES_RST));
				end
			endcase
			repeat (190) send_ray(rand_ray());
			idle_start();
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			if (sb.pending.size() != 0) sb.report("missing results", sb.pending.size(), 0);
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
`default_nettype wire
